// File: rtl/l6d_pkg.sv
`timescale 1ns / 1ps

package l6d_pkg;

   localparam int NUM_LANES   = 4;
   localparam int CODE_W      = 6;
   localparam int SLOT_ERROR  = 2 * NUM_LANES;
   localparam int NUM_SLOTS   = SLOT_ERROR + 1;
   localparam int SLOT_IDX_W  = $clog2(NUM_SLOTS);

   // result kinds
   localparam logic [2:0] KIND_LABEL        = 3'd0;
   localparam logic [2:0] KIND_SHIELD       = 3'd1;
   localparam logic [2:0] KIND_SHIELD_BEGIN = 3'd2;
   localparam logic [2:0] KIND_SPLIT        = 3'd3;
   localparam logic [2:0] KIND_END          = 3'd4;
   localparam logic [2:0] KIND_ERROR        = 3'd5;

   // character sets
   localparam logic [1:0] SET_NORMAL  = 2'd0;
   localparam logic [1:0] SET_SYMBOL  = 2'd1;
   localparam logic [1:0] SET_SPECIAL = 2'd2;

   // special codes
   localparam logic [5:0] CODE_SPACE         = 6'h00;
   localparam logic [5:0] CODE_SHIFT_SPECIAL = 6'h1b;
   localparam logic [5:0] CODE_SHIFT_SYMBOL  = 6'h1c;
   localparam logic [5:0] CODE_END           = 6'h1d;
   localparam logic [5:0] CODE_NEWLINE       = 6'h1e;
   localparam logic [5:0] CODE_SPLIT         = 6'h1f;
   localparam logic [5:0] SHIELD_BIAS        = 6'h29;
   localparam logic [5:0] CODE_SHIELD_FIRST  = 6'h2a;
   localparam logic [5:0] CODE_LAST_CHAR     = 6'h2f;

   localparam logic [6:0] ASCII_NEWLINE = 7'h0a;
   localparam logic [6:0] ASCII_TILDE   = 7'h7e;

   typedef struct packed {
      logic [23:0] packed_group;
      logic        label_start;
      logic        last_group;
   } req_word_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [6:0] char_code;
      logic [2:0] shield_kind;
      logic       run_end;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0] char_set;
      logic       in_shield;
      logic       label_nonempty;
      logic       split_taken;
      logic       finished;
   } dec_state_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [6:0] char_code;
      logic [2:0] shield_kind;
   } slot_type;

   typedef struct packed {
      logic     prim_valid;
      slot_type prim;
      logic     split_valid;
   } lane_out_type;

   function automatic logic [6:0] char_normal(input logic [5:0] c);
      logic [6:0] ch;
      ch = ASCII_TILDE;
      case (c) inside
         6'd0, 6'd30, 6'd31: ch = 7'h20;
         [6'd1:6'd26]:       ch = 7'h40 + {1'b0, c};
         [6'd32:6'd41]:      ch = 7'h10 + {1'b0, c};
         default:            ch = ASCII_TILDE;
      endcase
      return ch;
   endfunction

   function automatic logic [6:0] char_symbol(input logic [5:0] c);
      logic [6:0] ch;
      ch = ASCII_TILDE;
      case (c) inside
         6'd0:               ch = 7'h40;
         [6'd1:6'd15]:       ch = 7'h20 + {1'b0, c};
         [6'd26:6'd31]:      ch = 7'h20 + {1'b0, c};
         [6'd43:6'd47]:      ch = 7'h30 + {1'b0, c};
         default:            ch = ASCII_TILDE;
      endcase
      return ch;
   endfunction

   function automatic logic [6:0] char_special(input logic [5:0] c);
      logic [6:0] ch;
      ch = ASCII_TILDE;
      case (c) inside
         [6'd0:6'd26]:       ch = 7'h60 + {1'b0, c};
         [6'd32:6'd41]:      ch = 7'h10 + {1'b0, c};
         default:            ch = ASCII_TILDE;
      endcase
      return ch;
   endfunction

endpackage

// File: rtl/l6d_lane.sv
`timescale 1ns / 1ps

module l6d_lane (
   input  logic [5:0]              code,
   input  l6d_pkg::dec_state_type  state_cur,
   output l6d_pkg::dec_state_type  state_nxt,
   output l6d_pkg::lane_out_type   result
);
   import l6d_pkg::*;

   logic       normal;
   logic [6:0] shift_char;

   assign normal     = (state_cur.char_set != SET_SYMBOL) &&
                       (state_cur.char_set != SET_SPECIAL);
   assign shift_char = (state_cur.char_set == SET_SYMBOL) ? char_symbol(code)
                                                          : char_special(code);

   always_comb begin
      state_nxt = state_cur;
      result    = '0;
      if (!state_cur.finished) begin
         if ((code > CODE_LAST_CHAR) || (normal && code == CODE_END)) begin
            result.prim_valid = 1'b1;
            result.prim.kind  = KIND_END;
            state_nxt.finished = 1'b1;
         end else if (!normal) begin
            result.prim_valid     = 1'b1;
            result.prim.char_code = shift_char;
            result.prim.kind      = state_cur.in_shield ? KIND_SHIELD : KIND_LABEL;
            if (!state_cur.in_shield) state_nxt.label_nonempty = 1'b1;
            state_nxt.char_set = SET_NORMAL;
         end else if (code == CODE_SHIFT_SYMBOL) begin
            state_nxt.char_set = SET_SYMBOL;
         end else if (code == CODE_SHIFT_SPECIAL) begin
            state_nxt.char_set = SET_SPECIAL;
         end else if (code == CODE_NEWLINE || code == CODE_SPLIT) begin
            if (state_cur.in_shield) begin
               state_nxt.in_shield = 1'b0;
            end else begin
               if (state_cur.label_nonempty) begin
                  result.prim_valid     = 1'b1;
                  result.prim.kind      = KIND_LABEL;
                  result.prim.char_code = ASCII_NEWLINE;
               end
               if (code == CODE_SPLIT && !state_cur.split_taken) begin
                  result.split_valid    = 1'b1;
                  state_nxt.split_taken = 1'b1;
               end
            end
         end else if (code >= CODE_SHIELD_FIRST) begin
            result.prim_valid       = 1'b1;
            result.prim.kind        = KIND_SHIELD_BEGIN;
            result.prim.shield_kind = 3'(code - SHIELD_BIAS);
            state_nxt.in_shield     = 1'b1;
         end else if (state_cur.in_shield && code == CODE_SPACE) begin
            state_nxt.in_shield = 1'b0;
         end else begin
            result.prim_valid     = 1'b1;
            result.prim.char_code = char_normal(code);
            result.prim.kind      = state_cur.in_shield ? KIND_SHIELD : KIND_LABEL;
            if (!state_cur.in_shield) state_nxt.label_nonempty = 1'b1;
         end
      end
   end

endmodule

// File: rtl/l6d_merge.sv
`timescale 1ns / 1ps

module l6d_merge (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     load,
   input  logic [l6d_pkg::NUM_SLOTS-1:0]            load_valid,
   input  l6d_pkg::slot_type [l6d_pkg::NUM_SLOTS-1:0] load_slot,
   output logic                                     drain_ok,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output l6d_pkg::rsp_word_type                    rsp_data
);
   import l6d_pkg::*;

   logic [NUM_SLOTS-1:0]   mask_ff, mask_in;
   slot_type [NUM_SLOTS-1:0] slots_ff;
   logic [NUM_SLOTS-1:0]   pick;
   logic [NUM_SLOTS-1:0]   rest;
   logic [SLOT_IDX_W-1:0]  pick_idx;
   logic                   found;
   logic                   fire;

   // lowest pending slot goes out first
   always_comb begin
      pick     = '0;
      pick_idx = '0;
      found    = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (mask_ff[i] && !found) begin
            pick[i]  = 1'b1;
            pick_idx = SLOT_IDX_W'(i);
            found    = 1'b1;
         end
      end
   end

   assign rest      = mask_ff & ~pick;
   assign rsp_valid = |mask_ff;
   assign fire      = rsp_valid && rsp_ready;
   assign drain_ok  = (mask_ff == '0) || (fire && rest == '0);

   always_comb begin
      rsp_data.kind        = slots_ff[pick_idx].kind;
      rsp_data.char_code   = slots_ff[pick_idx].char_code;
      rsp_data.shield_kind = slots_ff[pick_idx].shield_kind;
      rsp_data.run_end     = (rest == '0);
   end

   always_comb begin
      mask_in = mask_ff;
      if (load) begin
         mask_in = load_valid;
      end else if (fire) begin
         mask_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slots_ff <= load_slot;
      end
   end

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (load && (load_valid != '0)) |=> rsp_valid)
      else $error("loaded results not presented");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> drain_ok)
      else $error("buffer overwritten while words pending");

endmodule

// File: rtl/label_6bit_decoder_core.sv
`timescale 1ns / 1ps

// Six-bit label text decoder.
// Request channel (req_valid/req_ready/req_data): one word carries a packed
// 3-byte group plus label_start and last_group flags. label_start clears the
// decoder state before the group is decoded.
// Response channel (rsp_valid/rsp_ready/rsp_data): zero to six words per
// group, in order; run_end marks the last word a group produced. A group that
// produces nothing (shifts, silent codes, groups after the end) yields no word.
// Four decode lanes handle the four codes of a group combinationally, chained
// through the decoder state; a merge buffer then drains the results one word
// per cycle while rsp_ready is high. The first word appears in the cycle after
// the group is taken. Throughput: one group per cycle when each group yields
// at most one word and the receiver is ready; else the buffer drain paces them.
// A new group is taken in the same cycle the last pending word is taken.
// Reset clears decoder state and the merge buffer. When the receiver stalls,
// the current word holds on rsp_data and req_ready stays low until the
// buffer is about to empty.

module label_6bit_decoder_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  l6d_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output l6d_pkg::rsp_word_type rsp_data
);
   import l6d_pkg::*;

   dec_state_type state_ff, state_in;
   dec_state_type lane_state [NUM_LANES+1];
   lane_out_type  lane_res   [NUM_LANES];

   logic                     accept;
   logic                     drain_ok;
   logic                     missing_term;
   logic [NUM_SLOTS-1:0]     slot_valid;
   slot_type [NUM_SLOTS-1:0] slot_data;

   assign req_ready = drain_ok;
   assign accept    = req_valid && req_ready;

   // start of a new label drops whatever the previous one left behind
   assign lane_state[0] = req_data.label_start ? dec_state_type'('0) : state_ff;

   // one lane per code, first code in the top bits
   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      l6d_lane u_lane (
         .code      (req_data.packed_group[23 - CODE_W*k -: CODE_W]),
         .state_cur (lane_state[k]),
         .state_nxt (lane_state[k+1]),
         .result    (lane_res[k])
      );

      assign slot_valid[2*k]   = lane_res[k].prim_valid;
      assign slot_data[2*k]    = lane_res[k].prim;
      assign slot_valid[2*k+1] = lane_res[k].split_valid;
      assign slot_data[2*k+1]  = '{kind: KIND_SPLIT, char_code: 7'd0, shield_kind: 3'd0};
   end

   // budget ran out without a terminator
   assign missing_term           = !lane_state[NUM_LANES].finished && req_data.last_group;
   assign slot_valid[SLOT_ERROR] = missing_term;
   assign slot_data[SLOT_ERROR]  = '{kind: KIND_ERROR, char_code: 7'd0, shield_kind: 3'd0};

   always_comb begin
      state_in = lane_state[NUM_LANES];
      if (missing_term) begin
         state_in.finished = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   l6d_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .load_valid (slot_valid),
      .load_slot  (slot_data),
      .drain_ok   (drain_ok),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // an end or error word is always the last of its group
   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.kind == KIND_END || rsp_data.kind == KIND_ERROR))
      |-> rsp_data.run_end)
      else $error("end or error word not last of group");

   // a finished label ignores groups until label_start
   a_finished_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff.finished && !req_data.label_start)
      |=> (state_ff == $past(state_ff)) && !rsp_valid)
      else $error("finished label changed state or produced words");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.kind <= KIND_ERROR))
      else $error("result kind out of range");

endmodule
